// ===== hdl/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

    // Field widths of the request and response beats
    localparam int MODE_W  = 2;
    localparam int CODE_W  = 8;
    localparam int ADDR_W  = 11;
    localparam int CELL_W  = 16;
    localparam int COL_O_W = 7;
    localparam int ROW_O_W = 5;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_PUT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RAW  = 2'd2;

    // Cell contents
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
    localparam logic [CODE_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CODE_W-1:0] NUL_CODE     = 8'h00;

endpackage

`default_nettype wire

// ===== hdl/text_console_writer.sv =====
`default_nettype none

// Text console writer: a COLUMNS x ROWS store of 16-bit text cells (attribute in the
// high byte, character in the low byte) and a cursor. Each request beat has two steps:
// one reads the addressed cell from the single-port-read cell memory into a registered
// read data word, and one writes the cell back where the mode needs it and loads the
// response; the second step waits while rsp_stall holds a finished response. A put
// that runs past the last row blanks every character and then holds requests while
// the sweep reads and rewrites each cell, one per cycle. After reset the block writes
// the blank cell 0x0720 into every entry before it accepts the first request. A new
// request may be taken while a finished response still waits on rsp_stall.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          req_valid,
    output logic                         req_stall,
    input  wire [tcw_pkg::MODE_W-1:0]    mode,
    input  wire [tcw_pkg::CODE_W-1:0]    char_code,
    input  wire [tcw_pkg::ADDR_W-1:0]    cell_address,
    input  wire [tcw_pkg::CELL_W-1:0]    cell_value,
    output logic                         rsp_valid,
    input  wire                          rsp_stall,
    output logic [tcw_pkg::CELL_W-1:0]   cell_word,
    output logic [tcw_pkg::COL_O_W-1:0]  cursor_col,
    output logic [tcw_pkg::ROW_O_W-1:0]  cursor_row,
    output logic                         screen_cleared
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int CMP_W = (AW > tcw_pkg::ADDR_W) ? AW : tcw_pkg::ADDR_W;

    localparam logic [AW-1:0]    LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0]    ROW_STEP  = AW'(COLUMNS);
    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);

    // Controller states
    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_CLEAR = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;

    logic [2:0] state_reg, state_next;

    // Cell memory
    logic [tcw_pkg::CELL_W-1:0] mem [CELLS];
    logic                       mem_rd_en;
    logic [AW-1:0]              mem_rd_addr;
    logic [tcw_pkg::CELL_W-1:0] rd_data_reg;
    logic                       mem_wr_en;
    logic [AW-1:0]              mem_wr_addr;
    logic [tcw_pkg::CELL_W-1:0] mem_wr_data;

    // Cursor
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [AW-1:0]    row_base_reg, row_base_next;

    // Sweep pointer and pending sweep write
    logic [AW-1:0] sweep_ptr_reg, sweep_ptr_next;
    logic          wr_pend_reg, wr_pend_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;

    // Latched request
    logic [tcw_pkg::MODE_W-1:0] mode_reg;
    logic [tcw_pkg::CODE_W-1:0] code_reg;
    logic [AW-1:0]              index_reg;
    logic                       in_range_reg;
    logic [tcw_pkg::CELL_W-1:0] value_reg;

    // Response register
    logic                        rsp_valid_reg, rsp_valid_next;
    logic [tcw_pkg::CELL_W-1:0]  cell_word_reg, cell_word_next;
    logic [COL_W-1:0]            rsp_col_reg, rsp_col_next;
    logic [ROW_W-1:0]            rsp_row_reg, rsp_row_next;
    logic                        cleared_reg, cleared_next;

    logic             req_accept;
    logic             rsp_free;
    logic [CMP_W-1:0] addr_ext;
    logic             addr_in_range;
    logic [AW-1:0]    cursor_idx;

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;

    assign addr_ext      = CMP_W'(cell_address);
    assign addr_in_range = (addr_ext < CMP_W'(CELLS));
    assign cursor_idx    = row_base_reg + AW'(col_reg);

    // Read port and registered read data
    always_ff @(posedge clk)
    begin
        if (mem_rd_en)
        begin
            rd_data_reg <= mem[mem_rd_addr];
        end
    end

    // Write port
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
    end

    // Hold the accepted request for the execute cycle
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            mode_reg     <= mode;
            code_reg     <= char_code;
            index_reg    <= addr_ext[AW-1:0];
            in_range_reg <= addr_in_range;
            value_reg    <= cell_value;
        end
    end

    // Sequence reset fill, request execution and screen blanking
    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        row_base_next  = row_base_reg;
        sweep_ptr_next = sweep_ptr_reg;
        wr_pend_next   = 1'b0;
        wr_addr_next   = wr_addr_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cell_word_next = cell_word_reg;
        rsp_col_next   = rsp_col_reg;
        rsp_row_next   = rsp_row_reg;
        cleared_next   = cleared_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = sweep_ptr_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = wr_addr_reg;
        mem_wr_data    = {rd_data_reg[tcw_pkg::CELL_W-1:tcw_pkg::CODE_W], tcw_pkg::SPACE_CODE};

        unique case (state_reg)
            S_INIT:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = sweep_ptr_reg;
                mem_wr_data = tcw_pkg::BLANK_CELL;
                if (sweep_ptr_reg == LAST_CELL)
                begin
                    sweep_ptr_next = '0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    sweep_ptr_next = sweep_ptr_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (req_accept)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = (mode == tcw_pkg::MODE_PUT) ? cursor_idx : addr_ext[AW-1:0];
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (rsp_free)
                begin
                    logic advance_row;
                    advance_row    = 1'b0;
                    cell_word_next = '0;
                    cleared_next   = 1'b0;
                    state_next     = S_IDLE;
                    case (mode_reg)
                        tcw_pkg::MODE_PUT:
                        begin
                            if (code_reg == tcw_pkg::NEWLINE_CODE)
                            begin
                                col_next    = '0;
                                advance_row = 1'b1;
                            end
                            else if (code_reg != tcw_pkg::NUL_CODE)
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = cursor_idx;
                                mem_wr_data = {rd_data_reg[tcw_pkg::CELL_W-1:tcw_pkg::CODE_W],
                                               code_reg};
                                if (col_reg == LAST_COL)
                                begin
                                    col_next    = '0;
                                    advance_row = 1'b1;
                                end
                                else
                                begin
                                    col_next = col_reg + COL_W'(1);
                                end
                            end
                        end
                        tcw_pkg::MODE_READ:
                        begin
                            cell_word_next = in_range_reg ? rd_data_reg : '0;
                        end
                        tcw_pkg::MODE_RAW:
                        begin
                            mem_wr_en   = in_range_reg;
                            mem_wr_addr = index_reg;
                            mem_wr_data = value_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (advance_row)
                    begin
                        if (row_reg == LAST_ROW)
                        begin
                            col_next       = '0;
                            row_next       = '0;
                            row_base_next  = '0;
                            cleared_next   = 1'b1;
                            sweep_ptr_next = '0;
                            state_next     = S_CLEAR;
                        end
                        else
                        begin
                            row_next      = row_reg + ROW_W'(1);
                            row_base_next = row_base_reg + ROW_STEP;
                        end
                    end
                    rsp_valid_next = 1'b1;
                    rsp_col_next   = col_next;
                    rsp_row_next   = row_next;
                end
            end

            S_CLEAR:
            begin
                mem_wr_en    = wr_pend_reg;
                mem_rd_en    = 1'b1;
                mem_rd_addr  = sweep_ptr_reg;
                wr_pend_next = 1'b1;
                wr_addr_next = sweep_ptr_reg;
                if (sweep_ptr_reg == LAST_CELL)
                begin
                    sweep_ptr_next = '0;
                    state_next     = S_DRAIN;
                end
                else
                begin
                    sweep_ptr_next = sweep_ptr_reg + AW'(1);
                end
            end

            S_DRAIN:
            begin
                mem_wr_en  = wr_pend_reg;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            col_reg       <= '0;
            row_reg       <= '0;
            row_base_reg  <= '0;
            sweep_ptr_reg <= '0;
            wr_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            row_base_reg  <= row_base_next;
            sweep_ptr_reg <= sweep_ptr_next;
            wr_pend_reg   <= wr_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        wr_addr_reg   <= wr_addr_next;
        cell_word_reg <= cell_word_next;
        rsp_col_reg   <= rsp_col_next;
        rsp_row_reg   <= rsp_row_next;
        cleared_reg   <= cleared_next;
    end

    // Drive the response beat
    assign rsp_valid      = rsp_valid_reg;
    assign cell_word      = cell_word_reg;
    assign cursor_col     = tcw_pkg::COL_O_W'(rsp_col_reg);
    assign cursor_row     = tcw_pkg::ROW_O_W'(rsp_row_reg);
    assign screen_cleared = cleared_reg;

    // Cursor always lies inside the screen
    assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= LAST_COL) && (row_reg <= LAST_ROW))
        else $error("cursor outside screen");

    // Row base tracks the cursor row
    assert property (@(posedge clk) disable iff (!rst_n)
        row_base_reg == AW'(row_reg * COLUMNS))
        else $error("row base out of step with row");

    // A blanking sweep starts only with a cleared response at home position
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) && (state_next == S_CLEAR) |=>
        rsp_valid_reg && cleared_reg && (rsp_col_reg == '0) && (rsp_row_reg == '0))
        else $error("blanking sweep without cleared response");

    // No cell write while waiting for a request
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_wr_en)
        else $error("cell write in idle");

    // Sweep pointer stays inside the store
    assert property (@(posedge clk) disable iff (!rst_n)
        sweep_ptr_reg <= LAST_CELL)
        else $error("sweep pointer out of range");

endmodule

`default_nettype wire
